[hdl/slfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length frame delineator package
// Shared constants and the command and status types between the frame
// delineator controller and its datapath.
// ----------------------------------------------------------------------------
package slfd_pkg;

	localparam int BUFFER_BYTES_DEF = 64;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	localparam int HEADER_BYTES   = 12;
	localparam int OVERHEAD_BYTES = 14;
	localparam int LEN_HI_POS     = 10;
	localparam int LEN_LO_POS     = 11;

	typedef enum logic [1:0] {
		RX_NONE,
		RX_START,
		RX_STORE,
		RX_CLEAR
	} rx_op_t;

	typedef struct packed {
		rx_op_t rx_op;
		logic   emit_start;
		logic   emit_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_one;
		logic full;
		logic is_first_sync;
		logic is_second_sync;
		logic hdr_end;
		logic len_bad;
		logic frame_done;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/slfd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame delineator datapath
// Holds the fill count, the frame buffer, the high length byte, the wanted
// frame length, the burst read register and the output register.
// ----------------------------------------------------------------------------
module slfd_datapath #(
	parameter int BUFFER_BYTES = slfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slfd_pkg::ctrl_cmd_t cmd,
	output slfd_pkg::dp_stat_t  stat,
	input  logic [7:0]          rx_byte,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          frame_byte,
	output logic [5:0]          byte_index,
	output logic                last_byte
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);

	logic [7:0]    mem [BUFFER_BYTES];
	logic [CW-1:0] fill_count_q;
	logic [7:0]    len_hi_q;
	logic [CW-1:0] want_q;
	logic [AW-1:0] emit_idx_q;
	logic [7:0]    rd_q;
	logic          out_valid_q;
	logic [7:0]    frame_byte_q;
	logic [5:0]    byte_index_q;
	logic          last_byte_q;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [CW-1:0] fill_next;

	assign fill_next = fill_count_q + CW'(1);
	assign wr_en     = (cmd.rx_op == slfd_pkg::RX_START) || (cmd.rx_op == slfd_pkg::RX_STORE);
	assign wr_addr   = (cmd.rx_op == slfd_pkg::RX_START) ? '0 : fill_count_q[AW-1:0];

	always_comb begin
		stat.fill_zero      = (fill_count_q == '0);
		stat.fill_one       = (fill_count_q == CW'(1));
		stat.full           = (fill_count_q >= CW'(BUFFER_BYTES));
		stat.is_first_sync  = (rx_byte == slfd_pkg::SYNC_FIRST);
		stat.is_second_sync = (rx_byte == slfd_pkg::SYNC_SECOND);
		stat.hdr_end        = (fill_count_q == CW'(slfd_pkg::LEN_LO_POS));
		stat.len_bad        = ({len_hi_q, rx_byte} >
			16'(BUFFER_BYTES - slfd_pkg::OVERHEAD_BYTES));
		stat.frame_done     = (fill_count_q >= CW'(slfd_pkg::HEADER_BYTES)) &&
			(fill_next == want_q);
		stat.emit_last      = ((CW'(emit_idx_q) + CW'(1)) == want_q);
		stat.out_free       = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_byte;
		end
		rd_q <= mem[emit_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit_start) begin
				fill_count_q <= '0;
			end else begin
				case (cmd.rx_op)
					slfd_pkg::RX_START: fill_count_q <= CW'(1);
					slfd_pkg::RX_STORE: fill_count_q <= fill_next;
					slfd_pkg::RX_CLEAR: fill_count_q <= '0;
					default:            fill_count_q <= fill_count_q;
				endcase
			end
			if (cmd.emit_start) begin
				emit_idx_q <= '0;
			end else if (cmd.emit_load) begin
				emit_idx_q <= emit_idx_q + AW'(1);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_op == slfd_pkg::RX_STORE &&
				fill_count_q == CW'(slfd_pkg::LEN_HI_POS)) begin
			len_hi_q <= rx_byte;
		end
		if (cmd.rx_op == slfd_pkg::RX_STORE && stat.hdr_end) begin
			want_q <= CW'(slfd_pkg::OVERHEAD_BYTES) + rx_byte[CW-1:0];
		end
		if (cmd.emit_load) begin
			frame_byte_q <= rd_q;
			byte_index_q <= 6'(emit_idx_q);
			last_byte_q  <= stat.emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign byte_index = byte_index_q;
	assign last_byte  = last_byte_q;

endmodule

[hdl/slfd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame delineator controller
// Decides what each received byte does to the frame in progress and steps
// the burst readout of a complete frame.
// ----------------------------------------------------------------------------
module slfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  slfd_pkg::dp_stat_t  stat,
	output slfd_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_RECV,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign accept   = in_valid && !in_stall_q;
	assign in_stall = in_stall_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_RECV: begin
				if (accept) begin
					if (stat.fill_zero) begin
						cmd.rx_op = stat.is_first_sync ? slfd_pkg::RX_START : slfd_pkg::RX_NONE;
					end else if (stat.fill_one && !stat.is_second_sync) begin
						cmd.rx_op = stat.is_first_sync ? slfd_pkg::RX_START : slfd_pkg::RX_CLEAR;
					end else if (stat.full) begin
						cmd.rx_op = slfd_pkg::RX_CLEAR;
					end else if (stat.hdr_end && stat.len_bad) begin
						cmd.rx_op = slfd_pkg::RX_CLEAR;
					end else begin
						cmd.rx_op      = slfd_pkg::RX_STORE;
						cmd.emit_start = stat.frame_done;
					end
				end
			end
			ST_LOAD: begin
				cmd.emit_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RECV;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RECV: begin
					if (cmd.emit_start) begin
						state_q    <= ST_READ;
						in_stall_q <= 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (stat.out_free && stat.emit_last) begin
						state_q    <= ST_RECV;
						in_stall_q <= 1'b0;
					end else if (stat.out_free) begin
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q    <= ST_RECV;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[hdl/sync_length_frame_delineator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length frame delineator
// Hunts for the sync pair, buffers the frame, checks the header length and
// sends a complete frame out as a burst of bytes with a last marker.
//
// Channel  Direction  Handshake            Payload
// in       receive    in_valid, in_stall   rx_byte
// out      send       out_valid, out_stall frame_byte, byte_index, last_byte
//
// While no frame is being sent, one byte is taken each cycle.
// A complete frame is sent byte by byte: each byte is read from the frame
// buffer into a read register, then loaded into the output register. The
// input is stalled for the whole burst.
// Reset clears the fill count, the controller and the output valid flag;
// the frame buffer is not cleared. A stalled output holds its transaction.
// ----------------------------------------------------------------------------
module sync_length_frame_delineator_core #(
	parameter int BUFFER_BYTES = slfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic [5:0] byte_index,
	output logic       last_byte
);

	slfd_pkg::ctrl_cmd_t cmd;
	slfd_pkg::dp_stat_t  stat;

	slfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	slfd_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.rx_byte    (rx_byte),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

endmodule

[hdl/slfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame delineator port checker
// Watches the ports of the frame delineator for frame structure and for
// stable stalled transactions on both channels.
// ----------------------------------------------------------------------------
module slfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic [5:0] byte_index,
	input logic       last_byte
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("Stalled input transaction changed.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) &&
			$stable(byte_index) && $stable(last_byte))
		else $error("Stalled output transaction changed.");

	a_first_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == 6'd0 |-> frame_byte == slfd_pkg::SYNC_FIRST)
		else $error("Frame does not open with the first sync byte.");

	a_second_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == 6'd1 |-> frame_byte == slfd_pkg::SYNC_SECOND)
		else $error("Second frame byte is not the second sync byte.");

	a_min_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> byte_index >= 6'(slfd_pkg::OVERHEAD_BYTES - 1))
		else $error("Frame ended shorter than its header and trailer.");

endmodule

bind sync_length_frame_delineator_core slfd_checker u_slfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.rx_byte    (rx_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.byte_index (byte_index),
	.last_byte  (last_byte)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sync/length frame delineator
// A driver sends received bytes from a queue and a monitor takes the frame
// bytes, both with random idle and stall gaps. A local deframer predicts every
// frame byte, and the monitor compares each output transaction with the oldest
// predicted one. Stimulus opens with sync, length and drop corner cases and
// then mixes random frames with bad lengths, broken sync pairs and noise.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int BUF_BYTES      = slfd_pkg::BUFFER_BYTES_DEF;
	localparam int MAX_PAYLOAD    = BUF_BYTES - slfd_pkg::OVERHEAD_BYTES;
	localparam int RX_TARGET      = 220;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 500;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] index;
		logic       last;
	} frame_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic [5:0] byte_index;
	logic       last_byte;

	logic [7:0]  rx_pending[$];
	frame_beat_t frame_bytes_due[$];

	logic [6:0] hold_count = '0;
	logic [7:0] held[BUF_BYTES];

	int          in_gap = 0;
	bit          in_calm = 1'b0;
	int          stall_left = 0;
	bit          out_calm = 1'b0;
	int          idle_cycles = 0;
	int          rx_taken = 0;
	int          rx_total = 0;
	int          bytes_out = 0;
	int          frames_out = 0;
	int          mismatches = 0;
	int          bad_len_sent = 0;
	int          broken_sync_sent = 0;
	frame_beat_t seen;
	frame_beat_t due;

	sync_length_frame_delineator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_byte(frame_byte),
		.byte_index(byte_index),
		.last_byte (last_byte)
	);

	always #6 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		int want;
		if (hold_count == 7'd0) begin
			if (b == slfd_pkg::SYNC_FIRST) begin
				held[0] = b;
				hold_count = 7'd1;
			end
			return;
		end
		if (hold_count == 7'd1 && b != slfd_pkg::SYNC_SECOND) begin
			hold_count = 7'd0;
			if (b == slfd_pkg::SYNC_FIRST) begin
				held[0] = b;
				hold_count = 7'd1;
			end
			return;
		end
		if (hold_count >= BUF_BYTES) begin
			hold_count = 7'd0;
			return;
		end
		held[hold_count[5:0]] = b;
		hold_count++;
		if (hold_count < slfd_pkg::HEADER_BYTES)
			return;
		want = slfd_pkg::OVERHEAD_BYTES +
			{held[slfd_pkg::LEN_HI_POS], held[slfd_pkg::LEN_LO_POS]};
		if (want > BUF_BYTES) begin
			hold_count = 7'd0;
			return;
		end
		if (hold_count != want)
			return;
		for (int k = 0; k < want; k++)
			frame_bytes_due.push_back('{held[k], 6'(k), k == want - 1});
		hold_count = 7'd0;
	endtask

	function automatic logic [7:0] body_byte(bit extreme, int pos);
		if (extreme)
			return pos[0] ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_header(int len_field, bit extreme);
		rx_pending.push_back(slfd_pkg::SYNC_FIRST);
		rx_pending.push_back(slfd_pkg::SYNC_SECOND);
		for (int i = 2; i < slfd_pkg::LEN_HI_POS; i++)
			rx_pending.push_back(body_byte(extreme, i));
		rx_pending.push_back(8'(len_field >> 8));
		rx_pending.push_back(8'(len_field));
	endtask

	task automatic push_frame(int payload, bit extreme);
		push_header(payload, extreme);
		for (int i = 0; i < payload + 2; i++)
			rx_pending.push_back(body_byte(extreme, i));
	endtask

	task automatic push_bad_length(int len_field);
		push_header(len_field, 1'b0);
		bad_len_sent++;
	endtask

	task automatic push_broken_sync();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == slfd_pkg::SYNC_SECOND)
			b = slfd_pkg::SYNC_FIRST;
		rx_pending.push_back(slfd_pkg::SYNC_FIRST);
		rx_pending.push_back(b);
		broken_sync_sent++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
				rx_taken++;
			end
			if ($urandom_range(0, 99) == 0)
				in_calm = !in_calm;
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (rx_pending.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
					in_gap = in_calm ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{frame_byte, byte_index, last_byte};
				bytes_out++;
				if (last_byte)
					frames_out++;
				if (frame_bytes_due.size() == 0) begin
					mismatches++;
					$display("%0t unexpected transaction: expected none, actual byte %02h index %0d last %0b",
						$time, seen.data, seen.index, seen.last);
				end else begin
					due = frame_bytes_due.pop_front();
					if (seen !== due) begin
						mismatches++;
						$display("%0t mismatch: expected byte %02h index %0d last %0b, actual byte %02h index %0d last %0b",
							$time, due.data, due.index, due.last, seen.data, seen.index, seen.last);
					end
				end
			end
			if ($urandom_range(0, 99) == 0)
				out_calm = !out_calm;
			if (stall_left == 0 && !out_calm)
				stall_left = idle_len();
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int payload;

		rx_pending.push_back(8'h00);
		rx_pending.push_back(8'hFF);
		rx_pending.push_back(slfd_pkg::SYNC_SECOND);
		push_broken_sync();
		rx_pending.push_back(slfd_pkg::SYNC_FIRST);
		push_frame(0, 1'b1);
		push_bad_length(MAX_PAYLOAD + 1);

		push_frame(MAX_PAYLOAD, 1'b0);
		push_bad_length(16'hFFFF);
		while (rx_pending.size() < RX_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if ($urandom_range(0, 19) == 0)
					payload = MAX_PAYLOAD;
				else if ($urandom_range(0, 9) == 0)
					payload = $urandom_range(9, MAX_PAYLOAD);
				else
					payload = $urandom_range(0, 8);
				push_frame(payload, 1'b0);
			end else if (r < 80) begin
				push_bad_length($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
			end else if (r < 88) begin
				push_broken_sync();
			end else begin
				repeat ($urandom_range(1, 4))
					rx_pending.push_back(8'($urandom_range(0, 255)));
			end
		end
		rx_total = rx_pending.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_taken < rx_total || frame_bytes_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes with %0d bad-length headers and %0d broken sync pairs.",
			rx_taken, bad_len_sent, broken_sync_sent);
		$display("Checked %0d frames, %0d frame bytes, %0d mismatches.",
			frames_out, bytes_out, mismatches);
		if (mismatches == 0 && frame_bytes_due.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[files.f]
hdl/slfd_pkg.sv
hdl/slfd_datapath.sv
hdl/slfd_ctrl.sv
hdl/sync_length_frame_delineator_core.sv
hdl/slfd_checker.sv
test/tb_top.sv
